// ===== src/iiee_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iiee_pkg
// Shared types, character codes and helpers for the infix expression
// evaluator.
// ----------------------------------------------------------------------------
package iiee_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam int         RADIX   = 10;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_MUL  = 2'd1,
        OP_DIV  = 2'd2,
        OP_RSVD = 2'd3
    } t_mul_op;

    typedef enum logic [2:0] {
        K_MUL = 3'd0,
        K_DIV = 3'd1,
        K_ADD = 3'd2,
        K_SUB = 3'd3,
        K_END = 3'd4
    } t_kind;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_DFIX = 7'b0001000,
        S_NEXT = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_RSV  = 7'b1000000
    } t_state;

    function automatic t_kind char_kind(input logic [7:0] c);
        t_kind k;
        k = K_END;
        unique case (c)
            CH_MUL:  k = K_MUL;
            CH_DIV:  k = K_DIV;
            CH_ADD:  k = K_ADD;
            CH_SUB:  k = K_SUB;
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] to_out(input t_value v);
        logic signed [63:0] wide;
        wide = 64'(signed'(v));
        return wide[OUT_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/infix_integer_expression_evaluator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator
// Evaluates a parenthesis-free infix integer expression, one ASCII character
// per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (i_s_*): one character per transfer in tdata[7:0]. Digits
//   build a number, '*' '/' bind tighter than '+' '-', evaluation is left to
//   right. Any other character ends the expression and yields one result.
//   Output stream (o_m_*): tdata carries the 32-bit wrapped value, tuser the
//   divide-by-zero flag. Only terminators produce a transfer.
//   Sequencing: a digit is taken in S_IDLE. An operator or terminator then
//   passes through S_NEXT, after S_MUL when a '*' is pending, or after
//   S_DIV and S_DFIX when a '/' with a non-zero divisor is pending. A
//   terminator then passes S_EMIT to load the output register. Multiply
//   and divide use the bit-serial shift/add-subtract unit shared with
//   the sum update; tready is low while it works.
//   Reset: synchronous, active low; clears r_sum, r_term, r_num and o_m_tvalid.
//   Stall: the result waits in the output register; a following expression
//   is still taken and evaluated, and its terminator holds until the
//   register is free.
// ----------------------------------------------------------------------------
module infix_integer_expression_evaluator
    import iiee_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output      logic                 o_s_tready,
    input  wire logic [7:0]           i_s_tdata,   // [7:0] char_code
    output      logic                 o_m_tvalid,
    input  wire logic                 i_m_tready,
    output      logic [OUT_WIDTH-1:0] o_m_tdata,   // [31:0] value
    output      logic                 o_m_tuser    // [0] div_zero
);

    t_state               r_state, n_state;
    t_value               r_sum, n_sum;
    t_value               r_term, n_term;
    t_value               r_num, n_num;
    t_mul_op              r_op, n_op;
    logic                 r_minus, n_minus;
    logic                 r_dz, n_dz;
    t_kind                r_kind, n_kind;
    t_value               r_a, n_a;
    t_value               r_b, n_b;
    t_value               r_rem, n_rem;
    logic                 r_neg, n_neg;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_WIDTH-1:0] r_out_value, n_out_value;
    logic                 r_out_dz, n_out_dz;

    t_value                alu_x, alu_y;
    logic                  alu_sub;
    logic [VALUE_WIDTH:0]  alu_res;
    t_value                rem_sh;
    logic                  accept, is_digit, cnt_last;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_dz;

    assign accept   = i_s_tvalid && o_s_tready;
    assign is_digit = (i_s_tdata >= CH_ZERO) && (i_s_tdata <= CH_NINE);
    assign cnt_last = (r_cnt == CNT_WIDTH'(VALUE_WIDTH - 1));
    assign rem_sh   = {r_rem[VALUE_WIDTH-2:0], r_a[VALUE_WIDTH-1]};

    // shared add/subtract unit, carry out of the top bit means no borrow
    always_comb begin
        alu_x   = r_sum;
        alu_y   = r_term;
        alu_sub = r_minus;
        unique case (r_state)
            S_MUL: begin
                alu_x   = r_rem;
                alu_y   = r_a;
                alu_sub = 1'b0;
            end
            S_DIV: begin
                alu_x   = rem_sh;
                alu_y   = r_b;
                alu_sub = 1'b1;
            end
            S_DFIX: begin
                alu_x   = '0;
                alu_y   = r_a;
                alu_sub = 1'b1;
            end
            default: begin
                alu_x   = r_sum;
                alu_y   = r_term;
                alu_sub = r_minus;
            end
        endcase
        alu_res = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                  + (VALUE_WIDTH+1)'(alu_sub);
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_term      = r_term;
        n_num       = r_num;
        n_op        = r_op;
        n_minus     = r_minus;
        n_dz        = r_dz;
        n_kind      = r_kind;
        n_a         = r_a;
        n_b         = r_b;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_value = r_out_value;
        n_out_dz    = r_out_dz;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_digit) begin
                        n_num = t_value'(r_num * t_value'(RADIX))
                                + t_value'(i_s_tdata - CH_ZERO);
                    end else begin
                        n_kind = char_kind(i_s_tdata);
                        n_num  = '0;
                        n_cnt  = '0;
                        n_state = S_NEXT;
                        case (r_op)
                            OP_MUL: begin
                                n_a     = r_term;
                                n_b     = r_num;
                                n_rem   = '0;
                                n_state = S_MUL;
                            end
                            OP_DIV: begin
                                if (r_num == '0) begin
                                    n_term = '0;
                                    n_dz   = 1'b1;
                                end else begin
                                    n_a     = r_term[VALUE_WIDTH-1] ? -r_term : r_term;
                                    n_b     = r_num[VALUE_WIDTH-1] ? -r_num : r_num;
                                    n_neg   = r_term[VALUE_WIDTH-1] ^ r_num[VALUE_WIDTH-1];
                                    n_rem   = '0;
                                    n_state = S_DIV;
                                end
                            end
                            default: n_term = r_num;
                        endcase
                    end
                end
            end
            S_MUL: begin
                if (r_b[0]) begin
                    n_rem = alu_res[VALUE_WIDTH-1:0];
                end
                n_a   = {r_a[VALUE_WIDTH-2:0], 1'b0};
                n_b   = {1'b0, r_b[VALUE_WIDTH-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_term  = r_b[0] ? alu_res[VALUE_WIDTH-1:0] : r_rem;
                    n_state = S_NEXT;
                end
            end
            S_DIV: begin
                n_rem = alu_res[VALUE_WIDTH] ? alu_res[VALUE_WIDTH-1:0] : rem_sh;
                n_a   = {r_a[VALUE_WIDTH-2:0], alu_res[VALUE_WIDTH]};
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = S_DFIX;
                end
            end
            S_DFIX: begin
                n_term  = r_neg ? alu_res[VALUE_WIDTH-1:0] : r_a;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                unique case (r_kind)
                    K_MUL: begin
                        n_op    = OP_MUL;
                        n_state = S_IDLE;
                    end
                    K_DIV: begin
                        n_op    = OP_DIV;
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_sum  = alu_res[VALUE_WIDTH-1:0];
                        n_term = '0;
                        n_op   = OP_NONE;
                        if (r_kind == K_ADD || r_kind == K_SUB) begin
                            n_minus = (r_kind == K_SUB);
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_value = to_out(r_sum);
                    n_out_dz    = r_dz;
                    n_sum       = '0;
                    n_term      = '0;
                    n_num       = '0;
                    n_op        = OP_NONE;
                    n_minus     = 1'b0;
                    n_dz        = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_term      <= '0;
            r_num       <= '0;
            r_op        <= OP_NONE;
            r_minus     <= 1'b0;
            r_dz        <= 1'b0;
            r_kind      <= K_END;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_term      <= n_term;
            r_num       <= n_num;
            r_op        <= n_op;
            r_minus     <= n_minus;
            r_dz        <= n_dz;
            r_kind      <= n_kind;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_rem       <= n_rem;
        r_neg       <= n_neg;
        r_out_value <= n_out_value;
        r_out_dz    <= n_out_dz;
    end

endmodule
`default_nettype wire
